// ===== hw/rtl/sbf_pkg.sv =====
package sbf_pkg;

    // Largest block piece one request can cause: channel, 4-byte length, control,
    // start time, rate and count.
    localparam int JOB_BYTES = 27;
    localparam int JOB_BITS  = JOB_BYTES * 8;
    localparam int CNT_W     = $clog2(JOB_BYTES + 1);
    localparam int IDX_W     = $clog2(JOB_BITS);

    localparam int MAX_SAMPLE_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // count * (sample bytes + timestamp) plus fixed header part
    localparam int PAYLOAD_W = 37;

    localparam logic [7:0] CTRL_START = 8'h06;
    localparam logic [7:0] CTRL_CONT  = 8'h05;
    localparam logic [7:0] CTRL_ABS   = 8'h08;
    localparam logic [7:0] CTRL_MULTI = 8'h80;

    localparam logic [PAYLOAD_W-1:0] LIMIT_SHORT = PAYLOAD_W'(32'h0000_FFFF);
    localparam logic [PAYLOAD_W-1:0] LIMIT_LONG  = PAYLOAD_W'(32'hFFFF_FFFF);

    localparam logic [2:0] LF_SHORT = 3'd2;
    localparam logic [2:0] LF_LONG  = 3'd4;

    typedef enum logic {
        OP_BEGIN  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CONT  = 2'd1,
        KIND_ABS   = 2'd2,
        KIND_ALT   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_COUNT = 3'd1,
        ST_BAD_LEN    = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_NO_FRAME   = 3'd4
    } status_t;

    typedef enum logic {
        REG_LEN_FIELD    = 1'b0,
        REG_SAMPLE_BYTES = 1'b1
    } reg_idx_t;

    // One queued job: bytes little end first, count of results, flags.
    typedef struct packed {
        logic [JOB_BITS-1:0] data;
        logic [CNT_W-1:0]    nbytes;
        logic                has_byte;
        status_t             status;
        logic                eof;
    } job_t;

endpackage

// ===== hw/rtl/sbf_front.sv =====
module sbf_front #(
    parameter int MAX_SAMPLE_BYTES = sbf_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [15:0]          s_channel,
    input  logic [1:0]           s_frame_kind,
    input  logic [31:0]          s_sample_count,
    input  logic signed [63:0]   s_start_time,
    input  logic [63:0]          s_rate_bits,
    input  logic signed [63:0]   s_sample_time,
    input  logic [63:0]          s_sample_bits,
    input  logic [2:0]           cfg_len_field,
    input  logic [3:0]           cfg_sample_bytes,
    input  logic                 q_full,
    output logic                 q_push,
    output sbf_pkg::job_t        q_job
);
    import sbf_pkg::*;

    logic                 frame_open_reg, frame_open_next;
    kind_t                open_kind_reg, open_kind_next;
    logic [31:0]          samples_left_reg, samples_left_next;

    logic [3:0]           sb_eff;
    kind_t                kind_eff;
    logic                 is_start, is_abs, multi;
    logic                 lf_short, lf_long;
    logic [4:0]           per;
    logic [PAYLOAD_W-1:0] product, payload;
    logic                 too_large;
    logic [7:0]           ctrl;
    logic [JOB_BITS-1:0]  hdr_data, smp_data;
    logic [CNT_W-1:0]     pos0, pos1, hdr_len, smp_len;
    logic [31:0]          left_dec;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // zero acts as one, oversize saturates
    always_comb begin
        if (cfg_sample_bytes == 4'd0) begin
            sb_eff = 4'd1;
        end else if (cfg_sample_bytes > 4'(MAX_SAMPLE_BYTES)) begin
            sb_eff = 4'(MAX_SAMPLE_BYTES);
        end else begin
            sb_eff = cfg_sample_bytes;
        end
    end

    assign kind_eff  = (kind_t'(s_frame_kind) == KIND_ALT) ? KIND_CONT : kind_t'(s_frame_kind);
    assign is_start  = (kind_eff == KIND_START);
    assign is_abs    = (kind_eff == KIND_ABS);
    assign multi     = (s_sample_count > 32'd1);
    assign lf_short  = (cfg_len_field == LF_SHORT);
    assign lf_long   = (cfg_len_field == LF_LONG);

    assign per       = {1'b0, sb_eff} + (is_abs ? 5'd8 : 5'd0);
    assign product   = PAYLOAD_W'(s_sample_count) * PAYLOAD_W'(per);
    assign payload   = product + PAYLOAD_W'(1) + (is_start ? PAYLOAD_W'(16) : PAYLOAD_W'(0))
                     + (multi ? PAYLOAD_W'(4) : PAYLOAD_W'(0));
    assign too_large = lf_short ? (payload > LIMIT_SHORT) : (payload > LIMIT_LONG);

    always_comb begin
        unique case (kind_eff)
            KIND_START: ctrl = CTRL_START;
            KIND_ABS:   ctrl = CTRL_ABS;
            default:    ctrl = CTRL_CONT;
        endcase
        if (multi) begin
            ctrl = ctrl | CTRL_MULTI;
        end
    end

    // header: channel, length, control, [start, rate], [count]
    always_comb begin
        hdr_data       = '0;
        hdr_data[15:0] = s_channel;
        if (lf_short) begin
            hdr_data[31:16] = payload[15:0];
            hdr_data[39:32] = ctrl;
            pos0            = CNT_W'(5);
        end else begin
            hdr_data[47:16] = payload[31:0];
            hdr_data[55:48] = ctrl;
            pos0            = CNT_W'(7);
        end
        pos1 = pos0;
        if (is_start) begin
            hdr_data[IDX_W'({pos0, 3'b000}) +: 64]           = s_start_time;
            hdr_data[IDX_W'({pos0 + CNT_W'(8), 3'b000}) +: 64] = s_rate_bits;
            pos1 = pos0 + CNT_W'(16);
        end
        hdr_len = pos1;
        if (multi) begin
            hdr_data[IDX_W'({pos1, 3'b000}) +: 32] = s_sample_count;
            hdr_len = pos1 + CNT_W'(4);
        end
    end

    // sample: [timestamp], low bytes of the value
    always_comb begin
        smp_data = '0;
        if (open_kind_reg == KIND_ABS) begin
            smp_data[63:0]   = s_sample_time;
            smp_data[127:64] = s_sample_bits;
            smp_len          = CNT_W'(sb_eff) + CNT_W'(8);
        end else begin
            smp_data[63:0] = s_sample_bits;
            smp_len        = CNT_W'(sb_eff);
        end
    end

    assign left_dec = samples_left_reg - 32'd1;

    always_comb begin
        frame_open_next   = frame_open_reg;
        open_kind_next    = open_kind_reg;
        samples_left_next = samples_left_reg;
        q_job             = '0;
        q_job.nbytes      = CNT_W'(1);
        q_job.status      = ST_OK;
        if (op_t'(s_op) == OP_BEGIN) begin
            frame_open_next = 1'b0;
            if (s_sample_count == 32'd0) begin
                q_job.status = ST_ZERO_COUNT;
            end else if (!lf_short && !lf_long) begin
                q_job.status = ST_BAD_LEN;
            end else if (too_large) begin
                q_job.status = ST_TOO_LARGE;
            end else begin
                q_job.data        = hdr_data;
                q_job.nbytes      = hdr_len;
                q_job.has_byte    = 1'b1;
                frame_open_next   = 1'b1;
                open_kind_next    = kind_eff;
                samples_left_next = s_sample_count;
            end
        end else if (!frame_open_reg) begin
            q_job.status = ST_NO_FRAME;
        end else begin
            q_job.data        = smp_data;
            q_job.nbytes      = smp_len;
            q_job.has_byte    = 1'b1;
            samples_left_next = left_dec;
            if (left_dec == 32'd0) begin
                frame_open_next = 1'b0;
                q_job.eof       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg   <= 1'b0;
            open_kind_reg    <= KIND_START;
            samples_left_reg <= '0;
        end else if (q_push) begin
            frame_open_reg   <= frame_open_next;
            open_kind_reg    <= open_kind_next;
            samples_left_reg <= samples_left_next;
        end
    end

endmodule

// ===== hw/rtl/sbf_queue.sv =====
module sbf_queue #(
    parameter int DEPTH = sbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sbf_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output sbf_pkg::job_t dout
);
    import sbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W2 = $clog2(DEPTH + 1);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W2-1:0] count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W2'(DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W2'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W2'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/sbf_back.sv =====
module sbf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  sbf_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_has_byte,
    output logic [2:0]    m_status,
    output logic          m_end_of_frame,
    output logic          m_last_of_run
);
    import sbf_pkg::*;

    logic                valid_reg, valid_next;
    logic [JOB_BITS-1:0] data_reg, data_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic                has_reg, has_next;
    status_t             st_reg, st_next;
    logic                eof_reg, eof_next;
    logic                last, advance;

    assign last    = (rem_reg == CNT_W'(1));
    assign advance = !valid_reg || m_ready;
    assign q_pop   = advance && (!valid_reg || last) && q_valid;

    // shift out one byte per cycle while m_ready is high, reload from the queue on the last one
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        has_next   = has_reg;
        st_next    = st_reg;
        eof_next   = eof_reg;
        if (advance) begin
            if (valid_reg && !last) begin
                data_next = data_reg >> 8;
                rem_next  = rem_reg - CNT_W'(1);
            end else if (q_valid) begin
                valid_next = 1'b1;
                data_next  = q_job.data;
                rem_next   = q_job.nbytes;
                has_next   = q_job.has_byte;
                st_next    = q_job.status;
                eof_next   = q_job.eof;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        has_reg  <= has_next;
        st_reg   <= st_next;
        eof_reg  <= eof_next;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = data_reg[7:0];
    assign m_has_byte     = has_reg;
    assign m_status       = st_reg;
    assign m_end_of_frame = eof_reg && last;
    assign m_last_of_run  = last;

endmodule

// ===== hw/rtl/sample_block_framer_top.sv =====
// The first result of a request goes through the job queue (front writes it) and then
//   into the output register (back loads it).
// The back's byte shifter gives one result per cycle while m_ready is high; a request
//   causes 1 to 27 results (16 for a timestamped 8-byte sample).
// Reset (aresetn low, synchronous): no frame open, queue empty, output idle,
//   length_field_bytes = 4, sample_bytes = 8.
module sample_block_framer_top #(
    parameter int MAX_SAMPLE_BYTES = sbf_pkg::MAX_SAMPLE_BYTES_DEF,
    parameter int QUEUE_DEPTH      = sbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [15:0]          s_channel,
    input  logic [1:0]           s_frame_kind,
    input  logic [31:0]          s_sample_count,
    input  logic signed [63:0]   s_start_time,
    input  logic [63:0]          s_rate_bits,
    input  logic signed [63:0]   s_sample_time,
    input  logic [63:0]          s_sample_bits,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_has_byte,
    output logic [2:0]           m_status,
    output logic                 m_end_of_frame,
    output logic                 m_last_of_run
);
    import sbf_pkg::*;

    logic [2:0] len_field_reg;
    logic [3:0] sample_bytes_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    logic       q_full, q_push, q_valid, q_pop;
    job_t       front_job, back_job;

    // ------------------------------------------------------------------
    // Config registers: reg 0 at 0x0, reg 1 at 0x4; pready is held high.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_field_reg    <= LF_LONG;
            sample_bytes_reg <= 4'd8;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LEN_FIELD:    len_field_reg    <= pwdata[2:0];
                REG_SAMPLE_BYTES: sample_bytes_reg <= pwdata[3:0];
                default:          len_field_reg    <= len_field_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LEN_FIELD:    prdata = {29'd0, len_field_reg};
            REG_SAMPLE_BYTES: prdata = {28'd0, sample_bytes_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: checks the request, tracks the open frame, packs the bytes
    // of the request into one job. Stalls only when the queue is full.
    // ------------------------------------------------------------------
    sbf_front #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_channel        (s_channel),
        .s_frame_kind     (s_frame_kind),
        .s_sample_count   (s_sample_count),
        .s_start_time     (s_start_time),
        .s_rate_bits      (s_rate_bits),
        .s_sample_time    (s_sample_time),
        .s_sample_bits    (s_sample_bits),
        .cfg_len_field    (len_field_reg),
        .cfg_sample_bytes (sample_bytes_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (front_job)
    );

    // Job queue decouples request intake from byte output.
    sbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_job),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (back_job)
    );

    // ------------------------------------------------------------------
    // Back: shifts each job out one byte per cycle while m_ready is high; the shifter is
    // the output register, so back-pressure stalls the front only once the queue fills.
    // ------------------------------------------------------------------
    sbf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_job          (back_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_status       (m_status),
        .m_end_of_frame (m_end_of_frame),
        .m_last_of_run  (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // an error is a single result carrying no byte
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_byte) |-> (m_last_of_run && !m_end_of_frame))
        else $error("error result not a lone last result");

    // block end closes the request's run and carries a byte
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_frame) |-> (m_last_of_run && m_has_byte))
        else $error("end of frame without last of run");

    // status is ok exactly on byte results
    a_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_has_byte == (m_status == ST_OK)))
        else $error("status and has_byte disagree");

    // a job is taken from the queue only when one waits
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Testbench for sample_block_framer_top.
// Requests go in on the s_ channel and the encoded block bytes come back on
// the m_ channel. A local encoder predicts every byte of every block from
// its own copy of the two registers and of the open-frame state. The
// prediction is made when a request is accepted. A monitor compares each
// returned result, field by field, against the oldest predicted byte.
module tb;
    import sbf_pkg::*;

    localparam int MAX_SAMPLE_BYTES = MAX_SAMPLE_BYTES_DEF;

    // one request as the sender sees it
    typedef struct {
        op_t                op;
        logic [15:0]        channel;
        kind_t              kind;
        logic [31:0]        count;
        logic signed [63:0] start_ns;
        logic [63:0]        rate_bits;
        logic signed [63:0] stamp_ns;
        logic [63:0]        sample_bits;
    } framer_req_t;

    // one result on the m_ channel
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        status_t    status;
        logic       eof;
        logic       last;
    } block_out_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // ---------------------------------------------------------------
    // DUT signals, every input driven to a known value from time zero
    // ---------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_op           = 1'b0;
    logic [15:0]        s_channel      = '0;
    logic [1:0]         s_frame_kind   = '0;
    logic [31:0]        s_sample_count = '0;
    logic signed [63:0] s_start_time   = '0;
    logic [63:0]        s_rate_bits    = '0;
    logic signed [63:0] s_sample_time  = '0;
    logic [63:0]        s_sample_bits  = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_has_byte;
    logic [2:0]         m_status;
    logic               m_end_of_frame;
    logic               m_last_of_run;

    // ---------------------------------------------------------------
    // Encoder copy of the block state and registers (reset values)
    // ---------------------------------------------------------------
    logic [2:0]  len_cfg = 3'd4;
    logic [3:0]  sb_cfg  = 4'd8;
    logic        fr_open = 1'b0;
    kind_t       fr_kind = KIND_START;
    logic [31:0] fr_left = '0;

    block_out_t  bytes_due[$];      // predicted results not yet returned

    int fail_count   = 0;
    int results_seen = 0;
    int items_sent   = 0;

    // sender burst control
    logic tx_live       = 1'b0;     // s_valid currently held high by us
    logic tx_gaps_on    = 1'b0;
    int   tx_burst_left = 0;

    // receiver control; rx_hold_left forces a long stall
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;

    sample_block_framer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_channel      (s_channel),
        .s_frame_kind   (s_frame_kind),
        .s_sample_count (s_sample_count),
        .s_start_time   (s_start_time),
        .s_rate_bits    (s_rate_bits),
        .s_sample_time  (s_sample_time),
        .s_sample_bits  (s_sample_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_status       (m_status),
        .m_end_of_frame (m_end_of_frame),
        .m_last_of_run  (m_last_of_run)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit: far above the slowest legal run.
    initial begin
        #20_000_000;
        $display("sample_block_framer_top: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, each one counted
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Block encoder
    // ---------------------------------------------------------------
    function automatic void push_le(logic [63:0] v, int n);
        block_out_t b;
        for (int i = 0; i < n; i++) begin
            b.data     = v[8*i +: 8];
            b.has_byte = 1'b1;
            b.status   = ST_OK;
            b.eof      = 1'b0;
            b.last     = 1'b0;
            bytes_due  = {bytes_due, b};
        end
    endfunction

    function automatic void push_error(status_t st);
        block_out_t b;
        b.data     = 8'h00;
        b.has_byte = 1'b0;
        b.status   = st;
        b.eof      = 1'b0;
        b.last     = 1'b0;
        bytes_due  = {bytes_due, b};
    endfunction

    // Appends every result that one accepted request causes.
    function automatic void frame_encode(framer_req_t r);
        logic [63:0] per;
        logic [63:0] payload;
        logic [63:0] limit;
        logic [7:0]  ctrl;
        int          sb;
        kind_t       k;
        logic        multi;

        // zero acts as one byte, anything over the max saturates
        if (sb_cfg == 4'd0)
            sb = 1;
        else if (int'(sb_cfg) > MAX_SAMPLE_BYTES)
            sb = MAX_SAMPLE_BYTES;
        else
            sb = int'(sb_cfg);

        if (r.op == OP_BEGIN) begin
            k       = (r.kind == KIND_ALT) ? KIND_CONT : r.kind;
            fr_open = 1'b0;        // any open frame is dropped
            multi   = (r.count > 32'd1);
            per     = 64'(sb) + ((k == KIND_ABS) ? 64'd8 : 64'd0);
            payload = 64'd1 + ((k == KIND_START) ? 64'd16 : 64'd0)
                    + (multi ? 64'd4 : 64'd0) + 64'(r.count) * per;
            limit   = (len_cfg == LF_SHORT) ? 64'(LIMIT_SHORT) : 64'(LIMIT_LONG);
            if (r.count == 32'd0) begin
                push_error(ST_ZERO_COUNT);
            end else if (len_cfg != LF_SHORT && len_cfg != LF_LONG) begin
                push_error(ST_BAD_LEN);
            end else if (payload > limit) begin
                push_error(ST_TOO_LARGE);
            end else begin
                if (k == KIND_START)
                    ctrl = CTRL_START;
                else if (k == KIND_ABS)
                    ctrl = CTRL_ABS;
                else
                    ctrl = CTRL_CONT;
                if (multi)
                    ctrl = ctrl | CTRL_MULTI;
                push_le(64'(r.channel), 2);
                push_le(payload, int'(len_cfg));
                push_le(64'(ctrl), 1);
                if (k == KIND_START) begin
                    push_le(r.start_ns, 8);
                    push_le(r.rate_bits, 8);
                end
                if (multi)
                    push_le(64'(r.count), 4);
                fr_open = 1'b1;
                fr_kind = k;
                fr_left = r.count;
            end
        end else if (!fr_open) begin
            push_error(ST_NO_FRAME);
        end else begin
            if (fr_kind == KIND_ABS)
                push_le(r.stamp_ns, 8);
            push_le(r.sample_bits, sb);
            fr_left = fr_left - 32'd1;
            if (fr_left == 32'd0) begin
                fr_open = 1'b0;
                bytes_due[bytes_due.size()-1].eof = 1'b1;
            end
        end
        bytes_due[bytes_due.size()-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Request builders: every field gets random bits
    // ---------------------------------------------------------------
    function automatic framer_req_t random_begin();
        framer_req_t r;
        r.op          = OP_BEGIN;
        r.channel     = 16'($urandom);
        r.kind        = kind_t'($urandom_range(0, 3));
        r.count       = $urandom;
        r.start_ns    = {$urandom, $urandom};
        r.rate_bits   = {$urandom, $urandom};
        r.stamp_ns    = {$urandom, $urandom};
        r.sample_bits = {$urandom, $urandom};
        return r;
    endfunction

    function automatic framer_req_t random_sample();
        framer_req_t r;
        r    = random_begin();
        r.op = OP_SAMPLE;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one request, then maybe a gap between bursts.
    // Valid stays high across back-to-back requests.
    // ---------------------------------------------------------------
    task automatic send_item(framer_req_t r);
        s_valid        <= 1'b1;
        s_op           <= r.op;
        s_channel      <= r.channel;
        s_frame_kind   <= r.kind;
        s_sample_count <= r.count;
        s_start_time   <= r.start_ns;
        s_rate_bits    <= r.rate_bits;
        s_sample_time  <= r.stamp_ns;
        s_sample_bits  <= r.sample_bits;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_ready);
        frame_encode(r);
        items_sent++;
        if (tx_gaps_on) begin
            if (tx_burst_left > 0) begin
                tx_burst_left--;
            end else begin
                tx_burst_left = $urandom_range(0, 11);
                s_valid <= 1'b0;
                tx_live = 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    endtask

    // Drop valid and wait until every predicted result is back.
    task automatic wait_idle();
        if (tx_live) begin
            s_valid <= 1'b0;
            tx_live = 1'b0;
        end
        while (bytes_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup, then access; written when pready is seen.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_LEN_FIELD)
            len_cfg = value[2:0];
        else
            sb_cfg = value[3:0];
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall patterns, plus a forced long hold-off
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(8, 80);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        block_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (bytes_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
            end else begin
                want = bytes_due.pop_front();
                if (m_out_byte !== want.data)
                    report_mismatch($sformatf("result %0d out_byte %h want %h",
                                              results_seen, m_out_byte, want.data));
                if (m_has_byte !== want.has_byte)
                    report_mismatch($sformatf("result %0d has_byte %b want %b",
                                              results_seen, m_has_byte, want.has_byte));
                if (m_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d want %0d",
                                              results_seen, m_status, want.status));
                if (m_end_of_frame !== want.eof)
                    report_mismatch($sformatf("result %0d end_of_frame %b want %b",
                                              results_seen, m_end_of_frame, want.eof));
                if (m_last_of_run !== want.last)
                    report_mismatch($sformatf("result %0d last_of_run %b want %b",
                                              results_seen, m_last_of_run, want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // sample request with nothing open
    task automatic test_no_frame();
        send_item(random_sample());
    endtask

    // count, length-size and payload-limit checks, in their priority order
    task automatic test_begin_errors();
        framer_req_t r;
        r = random_begin();
        r.count = 32'd0;
        send_item(r);                         // zero count, good length size
        wait_idle();
        write_reg(REG_LEN_FIELD, 32'd3);
        send_item(r);                         // zero count wins over bad size
        r.count = 32'd5;
        send_item(r);                         // bad length size
        wait_idle();
        write_reg(REG_LEN_FIELD, 32'(LF_SHORT));
        r.kind  = KIND_START;
        r.count = 32'h0000_FFFB;
        send_item(r);                         // far over the 16-bit limit
        wait_idle();
        write_reg(REG_SAMPLE_BYTES, 32'd1);
        r.kind  = KIND_CONT;
        r.count = 32'h0000_FFFA;              // payload exactly 0xFFFF: opens
        send_item(r);
        r.count = 32'h0000_FFFB;              // one over: fails, frame closed
        send_item(r);
        send_item(random_sample());           // no frame left
        wait_idle();
        write_reg(REG_LEN_FIELD, 32'(LF_LONG));
        r.count = 32'hFFFF_FFFF;
        send_item(r);                         // over the 32-bit limit
    endtask

    // each frame kind, field extremes, and a begin that drops an open frame
    task automatic test_frame_kinds();
        framer_req_t r;
        framer_req_t s;
        wait_idle();
        write_reg(REG_SAMPLE_BYTES, 32'd8);
        r = random_begin();
        r.kind      = KIND_START;
        r.count     = 32'd1;
        r.channel   = 16'hFFFF;
        r.start_ns  = 64'sh7FFF_FFFF_FFFF_FFFF;
        r.rate_bits = '1;
        send_item(r);
        s = random_sample();
        s.sample_bits = '1;
        send_item(s);
        // longest header, then dropped after one sample
        r.count     = 32'd2;
        r.channel   = 16'h0000;
        r.start_ns  = 64'sh8000_0000_0000_0000;
        r.rate_bits = '0;
        send_item(r);
        s.sample_bits = '0;
        send_item(s);
        r = random_begin();
        r.kind  = KIND_CONT;
        r.count = 32'd1;
        send_item(r);
        send_item(random_sample());
        r.kind  = KIND_ABS;
        r.count = 32'd2;
        send_item(r);
        s = random_sample();
        s.stamp_ns = 64'sh7FFF_FFFF_FFFF_FFFF;
        send_item(s);
        s.stamp_ns = 64'sh8000_0000_0000_0000;
        send_item(s);
        r.kind  = KIND_ALT;                   // encoded as continued
        r.count = 32'd1;
        send_item(r);
        send_item(random_sample());
    endtask

    // zero, oversized and odd sample sizes; a size change inside a frame
    task automatic test_sample_sizes();
        framer_req_t r;
        wait_idle();
        write_reg(REG_SAMPLE_BYTES, 32'd0);
        r = random_begin();
        r.kind  = KIND_CONT;
        r.count = 32'd2;
        send_item(r);
        send_item(random_sample());
        wait_idle();                          // frame still open here
        write_reg(REG_SAMPLE_BYTES, 32'd15);
        send_item(random_sample());
        wait_idle();
        write_reg(REG_SAMPLE_BYTES, 32'd3);
        r.kind  = KIND_ABS;
        r.count = 32'd1;
        send_item(r);
        send_item(random_sample());
    endtask

    // receiver holds off while the sender keeps offering requests, so the
    // block backs up and drops s_ready; then the sender waits for a full drain
    task automatic test_backpressure();
        framer_req_t r;
        wait_idle();
        write_reg(REG_LEN_FIELD, 32'(LF_LONG));
        write_reg(REG_SAMPLE_BYTES, 32'd8);
        tx_gaps_on   = 1'b0;
        rx_hold_left = 400;
        r = random_begin();
        r.kind  = KIND_ABS;
        r.count = 32'd20;
        send_item(r);
        repeat (20) send_item(random_sample());
        wait_idle();
    endtask

    // random phases: new register settings each phase, mostly whole frames
    task automatic test_random_traffic(int quota);
        framer_req_t r;
        logic [31:0] word;
        int          target;
        int          pick;
        int          n;
        target = items_sent + quota;
        while (items_sent < target) begin
            wait_idle();
            word = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                word[2:0] = LF_SHORT;
            else if (pick < 8)
                word[2:0] = LF_LONG;
            write_reg(REG_LEN_FIELD, word);
            write_reg(REG_SAMPLE_BYTES, $urandom);
            tx_gaps_on = ($urandom_range(0, 2) != 0);
            for (int p = 0; p < 40 && items_sent < target; p++) begin
                pick = $urandom_range(0, 99);
                r = random_begin();
                if (pick < 70) begin
                    // whole frame, sometimes cut short
                    r.count = $urandom_range(1, 6);
                    send_item(r);
                    n = r.count;
                    if ($urandom_range(0, 9) == 0)
                        n = $urandom_range(0, n - 1);
                    repeat (n) send_item(random_sample());
                end else if (pick < 80) begin
                    send_item(random_sample());
                end else if (pick < 88) begin
                    r.count = 32'd0;
                    send_item(r);
                end else begin
                    // full-range count: mostly too large, else a huge frame
                    send_item(r);
                    repeat ($urandom_range(0, 3)) send_item(random_sample());
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        int drain;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_no_frame();
        test_begin_errors();
        test_frame_kinds();
        test_sample_sizes();
        test_backpressure();
        test_random_traffic(480 - items_sent);

        // drain what is still in flight, then let the pipeline settle
        if (tx_live) begin
            s_valid <= 1'b0;
            tx_live = 1'b0;
        end
        drain = 0;
        while (bytes_due.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (16) @(posedge aclk);
        if (bytes_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", bytes_due.size()));

        if (fail_count == 0)
            $display("sample_block_framer_top: match");
        else
            $display("sample_block_framer_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_front.sv
hw/rtl/sbf_queue.sv
hw/rtl/sbf_back.sv
hw/rtl/sample_block_framer_top.sv
bench/tb.sv
